// File: hdl/assert_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B64_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define B64_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/b64dv_pkg.sv
// Types, constants and helper functions for the base64 decoder/validator.
package b64dv_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_is_status;
        logic        out_valid;
        logic [15:0] out_count;
        logic        out_last;
    } out_t;

    // One accepted character's worth of results, queued between front and back.
    typedef struct packed {
        logic                   has_data;
        logic [7:0]             data_byte;
        logic                   has_status;
        logic                   status_ok;
        logic [COUNT_WIDTH-1:0] count;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic is_sym;
        logic is_pad;
        logic [5:0] value;
    } sym_t;

    function automatic sym_t classify(input logic [7:0] c);
        sym_t r;
        r.is_sym = 1'b1;
        r.is_pad = 1'b0;
        r.value  = 6'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            r.value = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            r.value = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            r.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == CHAR_PLUS) begin
            r.value = 6'd62;
        end else if (c == CHAR_SLASH) begin
            r.value = 6'd63;
        end else if (c == CHAR_PAD) begin
            r.is_sym = 1'b0;
            r.is_pad = 1'b1;
        end else begin
            r.is_sym = 1'b0;
        end
        return r;
    endfunction

    // Low 16 bits of the count, zero-extended when the count is narrower.
    function automatic logic [15:0] count_to_port(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH+15:0] ext;
        ext = {16'd0, c};
        return ext[15:0];
    endfunction

endpackage

// File: hdl/b64dv_front.sv
// Front end: accepts characters, decodes symbols, tracks group and padding state.
`include "assert_macros.svh"
module b64dv_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  b64dv_pkg::in_t   s_data,
    input  logic             q_full,
    output logic             push,
    output b64dv_pkg::job_t  push_job
);
    import b64dv_pkg::*;

    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_HALF = 2'd1,
        PAD_DONE = 2'd2
    } pad_t;

    logic [1:0]             pos_reg, pos_next;
    logic [5:0]             prev_reg, prev_next;
    pad_t                   pad_reg, pad_next;
    logic                   err_reg, err_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    sym_t       sym;
    logic       emit;
    logic [7:0] dbyte;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        sym       = classify(s_data.in_char);
        err_next  = err_reg;
        pad_next  = pad_reg;
        prev_next = prev_reg;
        emit      = 1'b0;
        dbyte     = 8'd0;
        if (pad_reg == PAD_DONE || (!sym.is_sym && !sym.is_pad)) begin
            err_next = 1'b1;
        end else if (sym.is_pad) begin
            case (pos_reg)
                2'd2: begin
                    if (prev_reg[3:0] != 4'd0) err_next = 1'b1;
                    pad_next = PAD_HALF;
                end
                2'd3: begin
                    if (pad_reg == PAD_NONE && prev_reg[1:0] != 2'd0) err_next = 1'b1;
                    pad_next = PAD_DONE;
                end
                default: err_next = 1'b1;
            endcase
        end else begin
            if (pos_reg == 2'd3 && pad_reg == PAD_HALF) begin
                err_next = 1'b1;
            end else if (!err_reg) begin
                case (pos_reg)
                    2'd1: begin
                        emit  = 1'b1;
                        dbyte = {prev_reg, sym.value[5:4]};
                    end
                    2'd2: begin
                        emit  = 1'b1;
                        dbyte = {prev_reg[3:0], sym.value[5:2]};
                    end
                    2'd3: begin
                        emit  = 1'b1;
                        dbyte = {prev_reg[1:0], sym.value};
                    end
                    default: emit = 1'b0;
                endcase
            end
            prev_next = sym.value;
        end
        pos_next   = pos_reg + 2'd1;
        count_next = (emit && count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;

        push_job.has_data   = emit;
        push_job.data_byte  = dbyte;
        push_job.has_status = s_data.in_last;
        push_job.status_ok  = !err_next && pos_next == 2'd0;
        push_job.count      = count_next;
        push = accept && (emit || s_data.in_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 2'd0;
            prev_reg  <= 6'd0;
            pad_reg   <= PAD_NONE;
            err_reg   <= 1'b0;
            count_reg <= '0;
        end else if (accept) begin
            if (s_data.in_last) begin
                // start over for the next string
                pos_reg   <= 2'd0;
                prev_reg  <= 6'd0;
                pad_reg   <= PAD_NONE;
                err_reg   <= 1'b0;
                count_reg <= '0;
            end else begin
                pos_reg   <= pos_next;
                prev_reg  <= prev_next;
                pad_reg   <= pad_next;
                err_reg   <= err_next;
                count_reg <= count_next;
            end
        end
    end

    `B64_ASSERT_SAME(a_no_emit_after_err, aclk, aresetn, err_reg, !emit)
    `B64_ASSERT_NEXT(a_last_clears, aclk, aresetn, accept && s_data.in_last,
        pos_reg == 2'd0 && !err_reg && count_reg == '0)

endmodule

// File: hdl/b64dv_queue.sv
// Short job queue decoupling the front end from the output stage.
`include "assert_macros.svh"
module b64dv_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  b64dv_pkg::job_t       push_job,
    input  logic                  pop,
    output b64dv_pkg::job_t       head_job,
    output b64dv_pkg::q_status_t  status
);
    import b64dv_pkg::*;

    job_t               slots_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   fill_reg, fill_next;

    function automatic logic [FIFO_AW-1:0] bump(input logic [FIFO_AW-1:0] p);
        return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign status.full  = (fill_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign head_job     = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) fill_next = fill_reg + 1'b1;
        else if (pop && !push) fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slots_reg[wr_ptr_reg] <= push_job;
    end

    `B64_ASSERT_SAME(a_no_overflow, aclk, aresetn, push, !status.full)
    `B64_ASSERT_SAME(a_no_underflow, aclk, aresetn, pop, !status.empty)

endmodule

// File: hdl/b64dv_back.sv
// Back end: turns queued jobs into result beats through an output register.
`include "assert_macros.svh"
module b64dv_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  b64dv_pkg::job_t       head_job,
    input  b64dv_pkg::q_status_t  q_status,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output b64dv_pkg::out_t       m_data
);
    import b64dv_pkg::*;

    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;
    logic done_reg, done_next;   // data beat of the head job already sent
    logic load;
    logic send_data;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        load      = (!m_valid_reg || m_ready) && !q_status.empty;
        send_data = head_job.has_data && !done_reg;
        pop       = load && (!send_data || !head_job.has_status);
        done_next = load ? (send_data && head_job.has_status) : done_reg;

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
            if (send_data) begin
                m_data_next.out_byte      = head_job.data_byte;
                m_data_next.out_is_status = 1'b0;
                m_data_next.out_valid     = 1'b0;
                m_data_next.out_count     = 16'd0;
                m_data_next.out_last      = 1'b0;
            end else begin
                m_data_next.out_byte      = 8'd0;
                m_data_next.out_is_status = 1'b1;
                m_data_next.out_valid     = head_job.status_ok;
                m_data_next.out_count     = count_to_port(head_job.count);
                m_data_next.out_last      = 1'b1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    `B64_ASSERT_SAME(a_done_has_head, aclk, aresetn, done_reg,
        !q_status.empty && head_job.has_status)
    `B64_ASSERT_SAME(a_status_is_last, aclk, aresetn, m_valid_reg,
        m_data_reg.out_is_status == m_data_reg.out_last)

endmodule

// File: hdl/base64_decoder_validator_unit.sv
// Top level of the streaming base64 decoder and validator.
//
//  channel | dir | ports                     | beat
//  --------+-----+---------------------------+------------------------------------
//  s_      | in  | s_valid s_ready s_data    | one character, last flag on final
//  m_      | out | m_valid m_ready m_data    | one decoded byte or end-of-string status
//
// One character is accepted per cycle while the four-entry job queue has room.
// Each result is written into the job queue and then registered in the output register before it appears.
// The output register sends one beat per cycle while m_ready is high; a final character that also completes
// a byte yields two beats, its data byte first and then its status.
// Reset (aresetn low, synchronous) clears the string state, queue and output valid.
// Output stalls back up through the queue into s_ready only when the queue is full.
module base64_decoder_validator_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  b64dv_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output b64dv_pkg::out_t  m_data
);
    import b64dv_pkg::*;

    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head_job;
    q_status_t q_status;

    b64dv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_status.full),
        .push     (push),
        .push_job (push_job)
    );

    b64dv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    b64dv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
